// ----- hdl/mpsf_pkg.sv -----
// shared types and constants for the mqtt publish/subscribe framer
// holds the job record passed from the front end to the byte sequencer
// no dependencies
package mpsf_pkg;

    localparam int RL_W       = 28;
    localparam int FIFO_DEPTH = 4;
    localparam int PTR_W      = 2;
    localparam int CNT_W      = 3;

    localparam logic CMD_START   = 1'b0;
    localparam logic CMD_CONTENT = 1'b1;

    localparam logic [1:0] KIND_QOS0 = 2'd0;
    localparam logic [1:0] KIND_QOS1 = 2'd1;
    localparam logic [1:0] KIND_SUB  = 2'd2;
    localparam logic [1:0] KIND_NONE = 2'd3;

    localparam logic [7:0] TYPE_PUB0 = 8'h30;
    localparam logic [7:0] TYPE_PUB1 = 8'h32;
    localparam logic [7:0] TYPE_SUB  = 8'h82;
    localparam logic [7:0] SUB_QOS   = 8'h00;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_TOPIC,
        PH_DATA
    } t_phase;

    // what follows the last topic byte
    typedef enum logic [1:0] {
        AF_NONE,
        AF_SUB,
        AF_ID
    } t_after;

    typedef enum logic [3:0] {
        B_HEAD,
        B_VAR,
        B_SID_H,
        B_SID_L,
        B_LEN_H,
        B_LEN_L,
        B_TAIL_SUB,
        B_TAIL_IDH,
        B_TAIL_IDL
    } t_bst;

    typedef struct packed {
        logic            is_start;
        logic [1:0]      kind;
        logic [15:0]     tlen;
        logic [RL_W-1:0] rl;
        logic [1:0]      vcnt;
        logic [7:0]      data;
        logic            end_now;
        t_after          after;
        logic            id_last;
    } t_job;

endpackage

// ----- hdl/mqtt_publish_subscribe_framer_unit.sv -----
// mqtt 3.1.1 publish/subscribe framer, top level
// the first byte of an item passes through the job queue and the output register on its way out
// one frame byte per cycle from the sequencer while it holds a job and the output is not
// stalled; a content item gives its byte and any inserted tail, a start item its header bytes
// a 4-entry job queue lets the input keep going while header bytes drain
// reset (i_rst_n low, synchronous): no frame open, queue empty, packet id 1
module mqtt_publish_subscribe_framer_unit import mpsf_pkg::*; #(
    parameter int DATA_LEN_BITS = 24
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_command,
    input  logic [1:0]  i_frame_kind,
    input  logic [15:0] i_topic_len,
    input  logic [23:0] i_data_len,
    input  logic [7:0]  i_byte_in,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [7:0]  o_byte_out,
    output logic        o_frame_end
);

    logic w_push;
    logic w_pop;
    logic w_empty;
    logic w_full;
    t_job w_job_in;
    t_job w_job_head;

    mpsf_front #(
        .DATA_LEN_BITS(DATA_LEN_BITS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_command    (i_command),
        .i_frame_kind (i_frame_kind),
        .i_topic_len  (i_topic_len),
        .i_data_len   (i_data_len),
        .i_byte_in    (i_byte_in),
        .i_full       (w_full),
        .o_push       (w_push),
        .o_job        (w_job_in)
    );

    mpsf_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_job_in),
        .i_pop   (w_pop),
        .o_job   (w_job_head),
        .o_empty (w_empty),
        .o_full  (w_full)
    );

    mpsf_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job       (w_job_head),
        .i_empty     (w_empty),
        .o_pop       (w_pop),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_byte_out  (o_byte_out),
        .o_frame_end (o_frame_end)
    );

endmodule

// ----- hdl/mpsf_front.sv -----
// front end: accepts items, tracks the open frame and turns each framed item into a job
// depends on mpsf_pkg
module mpsf_front import mpsf_pkg::*; #(
    parameter int DATA_LEN_BITS = 24
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_command,
    input  logic [1:0]  i_frame_kind,
    input  logic [15:0] i_topic_len,
    input  logic [23:0] i_data_len,
    input  logic [7:0]  i_byte_in,
    input  logic        i_full,
    output logic        o_push,
    output t_job        o_job
);

    t_phase                   r_phase, n_phase;
    logic [1:0]               r_kind, n_kind;
    logic [15:0]              r_topic_left, n_topic_left;
    logic [DATA_LEN_BITS-1:0] r_data_left, n_data_left;

    logic                     w_acc;
    logic                     w_start;
    logic                     w_kind_ok;
    logic [DATA_LEN_BITS-1:0] w_dlen;
    logic [DATA_LEN_BITS-1:0] w_dlen_new;
    logic                     w_dnew_empty;
    logic                     w_dold_empty;
    logic [15:0]              w_tl1;
    logic [DATA_LEN_BITS-1:0] w_dl1;
    logic [31:0]              w_rl;
    logic [1:0]               w_vcnt;

    function automatic t_phase close_phase(input logic [1:0] kind, input logic dempty);
        return (kind == KIND_SUB || dempty) ? PH_IDLE : PH_DATA;
    endfunction

    function automatic t_after after_of(input logic [1:0] kind);
        t_after a;
        case (kind)
            KIND_SUB:  a = AF_SUB;
            KIND_QOS1: a = AF_ID;
            default:   a = AF_NONE;
        endcase
        return a;
    endfunction

    assign o_stall      = i_full;
    assign w_acc        = i_valid && !i_full;
    assign w_start      = (i_command == CMD_START);
    assign w_kind_ok    = (i_frame_kind != KIND_NONE);
    assign w_dlen       = DATA_LEN_BITS'(i_data_len);
    assign w_dlen_new   = (i_frame_kind == KIND_SUB) ? '0 : w_dlen;
    assign w_dnew_empty = (w_dlen_new == '0);
    assign w_dold_empty = (r_data_left == '0);
    assign w_tl1        = r_topic_left - 16'd1;
    assign w_dl1        = r_data_left - DATA_LEN_BITS'(1);

    // remaining length, always below 2^28
    always_comb begin
        case (i_frame_kind)
            KIND_SUB:  w_rl = 32'(i_topic_len) + 32'd5;
            KIND_QOS1: w_rl = 32'(i_topic_len) + 32'(w_dlen_new) + 32'd4;
            default:   w_rl = 32'(i_topic_len) + 32'(w_dlen_new) + 32'd2;
        endcase
        if (w_rl >= 32'h0020_0000) begin
            w_vcnt = 2'd3;
        end else if (w_rl >= 32'h0000_4000) begin
            w_vcnt = 2'd2;
        end else if (w_rl >= 32'h0000_0080) begin
            w_vcnt = 2'd1;
        end else begin
            w_vcnt = 2'd0;
        end
    end

    // next state
    always_comb begin
        n_phase      = r_phase;
        n_kind       = r_kind;
        n_topic_left = r_topic_left;
        n_data_left  = r_data_left;
        if (w_acc) begin
            if (w_start) begin
                n_phase = PH_IDLE;
                if (w_kind_ok) begin
                    n_kind       = i_frame_kind;
                    n_topic_left = i_topic_len;
                    n_data_left  = w_dlen_new;
                    if (i_topic_len == 16'd0) begin
                        n_phase = close_phase(i_frame_kind, w_dnew_empty);
                    end else begin
                        n_phase = PH_TOPIC;
                    end
                end
            end else begin
                case (r_phase)
                    PH_TOPIC: begin
                        n_topic_left = w_tl1;
                        if (w_tl1 == 16'd0) begin
                            n_phase = close_phase(r_kind, w_dold_empty);
                        end
                    end
                    PH_DATA: begin
                        n_data_left = w_dl1;
                        if (w_dl1 == '0) begin
                            n_phase = PH_IDLE;
                        end
                    end
                    default: ;
                endcase
            end
        end
    end

    // job output
    always_comb begin
        o_push = 1'b0;
        o_job  = '0;
        o_job.data = i_byte_in;
        if (w_acc) begin
            if (w_start) begin
                if (w_kind_ok) begin
                    o_push         = 1'b1;
                    o_job.is_start = 1'b1;
                    o_job.kind     = i_frame_kind;
                    o_job.tlen     = i_topic_len;
                    o_job.rl       = w_rl[RL_W-1:0];
                    o_job.vcnt     = w_vcnt;
                    if (i_topic_len == 16'd0) begin
                        o_job.after   = after_of(i_frame_kind);
                        o_job.id_last = w_dnew_empty;
                        o_job.end_now = (i_frame_kind == KIND_QOS0) && w_dnew_empty;
                    end
                end
            end else begin
                case (r_phase)
                    PH_TOPIC: begin
                        o_push = 1'b1;
                        if (w_tl1 == 16'd0) begin
                            o_job.after   = after_of(r_kind);
                            o_job.id_last = w_dold_empty;
                            o_job.end_now = (r_kind == KIND_QOS0) && w_dold_empty;
                        end
                    end
                    PH_DATA: begin
                        o_push        = 1'b1;
                        o_job.end_now = (w_dl1 == '0);
                    end
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_IDLE;
            r_kind       <= KIND_QOS0;
            r_topic_left <= '0;
            r_data_left  <= '0;
        end else begin
            r_phase      <= n_phase;
            r_kind       <= n_kind;
            r_topic_left <= n_topic_left;
            r_data_left  <= n_data_left;
        end
    end

    a_topic_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_TOPIC) |-> (r_topic_left != 16'd0))
        else $error("topic phase with no topic bytes left");

    a_data_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_DATA) |-> (r_data_left != '0))
        else $error("data phase with no payload bytes left");

endmodule

// ----- hdl/mpsf_fifo.sv -----
// short job queue between the front end and the byte sequencer
// depends on mpsf_pkg
module mpsf_fifo import mpsf_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    input  logic i_pop,
    output t_job o_job,
    output logic o_empty,
    output logic o_full
);

    t_job             r_mem [FIFO_DEPTH];
    logic [PTR_W-1:0] r_wptr, r_rptr;
    logic [CNT_W-1:0] r_cnt;
    logic             w_do_pop;

    assign o_empty  = (r_cnt == CNT_W'(0));
    assign o_full   = (r_cnt == CNT_W'(FIFO_DEPTH));
    assign o_job    = r_mem[r_rptr];
    assign w_do_pop = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + PTR_W'(1);
            end
            if (w_do_pop) begin
                r_rptr <= r_rptr + PTR_W'(1);
            end
            if (i_push && !w_do_pop) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end else if (!i_push && w_do_pop) begin
                r_cnt <= r_cnt - CNT_W'(1);
            end
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("job pushed into full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty)
        else $error("job popped from empty queue");

endmodule

// ----- hdl/mpsf_back.sv -----
// byte sequencer: expands the job at the queue head into frame bytes
// owns the packet identifier counter and the output register; depends on mpsf_pkg
module mpsf_back import mpsf_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_job       i_job,
    input  logic       i_empty,
    output logic       o_pop,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_byte_out,
    output logic       o_frame_end
);

    t_bst        r_st, n_st;
    logic [1:0]  r_vidx, n_vidx;
    logic [15:0] r_pid;
    logic        r_ov;
    logic [7:0]  r_byte;
    logic        r_end;

    logic        w_adv;
    logic [7:0]  w_byte;
    logic        w_end;
    logic        w_pop;
    logic        w_inc;
    logic [6:0]  w_vbits;
    logic [7:0]  w_type;
    t_bst        w_tail;

    assign w_adv = !i_empty && (!r_ov || !i_stall);

    always_comb begin
        case (r_vidx)
            2'd0:    w_vbits = i_job.rl[6:0];
            2'd1:    w_vbits = i_job.rl[13:7];
            2'd2:    w_vbits = i_job.rl[20:14];
            default: w_vbits = i_job.rl[27:21];
        endcase
        case (i_job.kind)
            KIND_SUB:  w_type = TYPE_SUB;
            KIND_QOS1: w_type = TYPE_PUB1;
            default:   w_type = TYPE_PUB0;
        endcase
        case (i_job.after)
            AF_SUB:  w_tail = B_TAIL_SUB;
            AF_ID:   w_tail = B_TAIL_IDH;
            default: w_tail = B_HEAD;
        endcase
    end

    // next state
    always_comb begin
        n_st   = r_st;
        n_vidx = r_vidx;
        if (w_adv) begin
            case (r_st)
                B_HEAD: begin
                    n_vidx = 2'd0;
                    n_st   = i_job.is_start ? B_VAR : w_tail;
                end
                B_VAR: begin
                    n_vidx = r_vidx + 2'd1;
                    if (r_vidx == i_job.vcnt) begin
                        n_st = (i_job.kind == KIND_SUB) ? B_SID_H : B_LEN_H;
                    end
                end
                B_SID_H:    n_st = B_SID_L;
                B_SID_L:    n_st = B_LEN_H;
                B_LEN_H:    n_st = B_LEN_L;
                B_LEN_L:    n_st = w_tail;
                B_TAIL_SUB: n_st = B_HEAD;
                B_TAIL_IDH: n_st = B_TAIL_IDL;
                B_TAIL_IDL: n_st = B_HEAD;
                default:    n_st = B_HEAD;
            endcase
        end
    end

    // byte for the current step
    always_comb begin
        w_byte = 8'h00;
        w_end  = 1'b0;
        w_pop  = 1'b0;
        w_inc  = 1'b0;
        case (r_st)
            B_HEAD: begin
                if (i_job.is_start) begin
                    w_byte = w_type;
                end else begin
                    w_byte = i_job.data;
                    w_end  = i_job.end_now;
                    w_pop  = (i_job.after == AF_NONE);
                end
            end
            B_VAR:   w_byte = {(r_vidx != i_job.vcnt), w_vbits};
            B_SID_H: w_byte = r_pid[15:8];
            B_SID_L: begin
                w_byte = r_pid[7:0];
                w_inc  = 1'b1;
            end
            B_LEN_H: w_byte = i_job.tlen[15:8];
            B_LEN_L: begin
                w_byte = i_job.tlen[7:0];
                w_end  = i_job.end_now;
                w_pop  = (i_job.after == AF_NONE);
            end
            B_TAIL_SUB: begin
                w_byte = SUB_QOS;
                w_end  = 1'b1;
                w_pop  = 1'b1;
            end
            B_TAIL_IDH: w_byte = r_pid[15:8];
            B_TAIL_IDL: begin
                w_byte = r_pid[7:0];
                w_end  = i_job.id_last;
                w_pop  = 1'b1;
                w_inc  = 1'b1;
            end
            default: ;
        endcase
    end

    assign o_pop       = w_adv && w_pop;
    assign o_valid     = r_ov;
    assign o_byte_out  = r_byte;
    assign o_frame_end = r_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st   <= B_HEAD;
            r_vidx <= '0;
            r_pid  <= 16'd1;
            r_ov   <= 1'b0;
        end else begin
            r_st   <= n_st;
            r_vidx <= n_vidx;
            if (w_adv && w_inc) begin
                r_pid <= r_pid + 16'd1;
            end
            if (w_adv) begin
                r_ov <= 1'b1;
            end else if (!i_stall) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_byte <= w_byte;
            r_end  <= w_end;
        end
    end

    // a job stays at the head until its last byte is loaded into the output register
    a_mid_job: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st != B_HEAD) |-> !i_empty)
        else $error("sequencer mid-job with empty queue");

    a_var_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == B_VAR) |-> (r_vidx <= i_job.vcnt))
        else $error("length byte index past last length byte");

endmodule

// ----- tb/mpsf_frame_checker.sv -----
// frame checker for the mqtt publish/subscribe framer: watches the item and byte
// channels, predicts every frame byte and compares it with what the block sends
// depends on mpsf_pkg
module mpsf_frame_checker import mpsf_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  logic        i_command,
    input  logic [1:0]  i_frame_kind,
    input  logic [15:0] i_topic_len,
    input  logic [23:0] i_data_len,
    input  logic [7:0]  i_byte_in,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  logic [7:0]  i_byte_out,
    input  logic        i_frame_end,
    output int          o_fail_count,
    output int          o_bytes_pending
);

    localparam logic [7:0] VARINT_MORE = 8'h80;

    typedef struct packed {
        logic [7:0] value;
        logic       last;
    } t_wire_byte;

    t_wire_byte  frame_bytes_q[$];
    t_phase      phase_q;
    logic [1:0]  kind_q;
    logic [15:0] topic_left;
    logic [23:0] data_left;
    logic [15:0] next_id;
    int          fails = 0;

    initial begin
        o_fail_count    = 0;
        o_bytes_pending = 0;
    end

    task automatic push_byte(input logic [7:0] value, input logic last);
        t_wire_byte w;
        w.value = value;
        w.last  = last;
        frame_bytes_q.push_back(w);
    endtask

    // identifier goes out high byte first and is consumed once sent
    task automatic emit_packet_id(input logic last);
        push_byte(next_id[15:8], 1'b0);
        push_byte(next_id[7:0], last);
        next_id = next_id + 16'd1;
    endtask

    task automatic close_topic();
        t_wire_byte tail;
        if (kind_q == KIND_SUB) begin
            push_byte(SUB_QOS, 1'b1);
            phase_q = PH_IDLE;
        end else if (kind_q == KIND_QOS1) begin
            emit_packet_id(data_left == '0);
            phase_q = (data_left == '0) ? PH_IDLE : PH_DATA;
        end else if (data_left == '0) begin
            // qos0 with no payload: the byte just queued closes the frame
            tail = frame_bytes_q.pop_back();
            tail.last = 1'b1;
            frame_bytes_q.push_back(tail);
            phase_q = PH_IDLE;
        end else begin
            phase_q = PH_DATA;
        end
    endtask

    task automatic predict_frame_bytes(input logic cmd, input logic [1:0] kind,
                                       input logic [15:0] tlen, input logic [23:0] dlen,
                                       input logic [7:0] value);
        logic [31:0] rem_len;
        logic [7:0]  digit;
        logic [7:0]  type_byte;
        if (cmd == CMD_START) begin
            phase_q = PH_IDLE;
            if (kind != KIND_NONE) begin
                kind_q     = kind;
                topic_left = tlen;
                data_left  = (kind == KIND_SUB) ? 24'd0 : dlen;
                case (kind)
                    KIND_SUB: begin
                        rem_len   = 32'd5 + tlen;
                        type_byte = TYPE_SUB;
                    end
                    KIND_QOS1: begin
                        rem_len   = 32'd4 + tlen + dlen;
                        type_byte = TYPE_PUB1;
                    end
                    default: begin
                        rem_len   = 32'd2 + tlen + dlen;
                        type_byte = TYPE_PUB0;
                    end
                endcase
                push_byte(type_byte, 1'b0);
                do begin
                    digit   = {1'b0, rem_len[6:0]};
                    rem_len = rem_len >> 7;
                    if (rem_len != 0) digit = digit | VARINT_MORE;
                    push_byte(digit, 1'b0);
                end while (rem_len != 0);
                if (kind == KIND_SUB) emit_packet_id(1'b0);
                push_byte(tlen[15:8], 1'b0);
                push_byte(tlen[7:0], 1'b0);
                if (tlen == '0) close_topic();
                else phase_q = PH_TOPIC;
            end
        end else if (phase_q == PH_TOPIC) begin
            push_byte(value, 1'b0);
            topic_left = topic_left - 16'd1;
            if (topic_left == '0) close_topic();
        end else if (phase_q == PH_DATA) begin
            data_left = data_left - 24'd1;
            push_byte(value, data_left == '0);
            if (data_left == '0) phase_q = PH_IDLE;
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_wire_byte want;
        if (!i_rst_n) begin
            phase_q    = PH_IDLE;
            kind_q     = KIND_QOS0;
            topic_left = '0;
            data_left  = '0;
            next_id    = 16'd1;
            frame_bytes_q.delete();
        end else begin
            // results first, so a stray byte is never matched to this edge's item
            if (i_out_valid && !i_out_stall) begin
                if (frame_bytes_q.size() == 0) begin
                    $display("%0t: unexpected byte %02h end %0b, nothing expected",
                             $time, i_byte_out, i_frame_end);
                    fails++;
                end else begin
                    want = frame_bytes_q.pop_front();
                    if (i_byte_out !== want.value) begin
                        $display("%0t: byte_out expected %02h got %02h",
                                 $time, want.value, i_byte_out);
                        fails++;
                    end
                    if (i_frame_end !== want.last) begin
                        $display("%0t: frame_end expected %0b got %0b",
                                 $time, want.last, i_frame_end);
                        fails++;
                    end
                end
            end
            if (i_in_valid && !i_in_stall)
                predict_frame_bytes(i_command, i_frame_kind, i_topic_len, i_data_len,
                                    i_byte_in);
        end
        o_fail_count    <= fails;
        o_bytes_pending <= frame_bytes_q.size();
    end

endmodule

// ----- tb/testbench.sv -----
// top of the mqtt framer testbench: clock, reset, item stimulus and byte sink
// depends on mpsf_pkg, mqtt_publish_subscribe_framer_unit and mpsf_frame_checker
module testbench import mpsf_pkg::*; ();

    localparam int RUN_LIMIT    = 4_000_000;
    localparam int DRAIN_CYCLES = 8;
    localparam int RANDOM_ITEMS = 500;

    logic        i_clk        = 1'b0;
    logic        i_rst_n      = 1'b0;
    logic        i_valid      = 1'b0;
    logic        i_command    = CMD_START;
    logic [1:0]  i_frame_kind = KIND_QOS0;
    logic [15:0] i_topic_len  = '0;
    logic [23:0] i_data_len   = '0;
    logic [7:0]  i_byte_in    = '0;
    logic        i_stall      = 1'b0;
    logic        o_stall;
    logic        o_valid;
    logic [7:0]  o_byte_out;
    logic        o_frame_end;

    int fail_count;
    int bytes_pending;
    int items_sent = 0;
    int take_wait  = 0;
    bit send_idle  = 1'b1;
    bit take_idle  = 1'b1;

    mqtt_publish_subscribe_framer_unit dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_command    (i_command),
        .i_frame_kind (i_frame_kind),
        .i_topic_len  (i_topic_len),
        .i_data_len   (i_data_len),
        .i_byte_in    (i_byte_in),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_byte_out   (o_byte_out),
        .o_frame_end  (o_frame_end)
    );

    mpsf_frame_checker frame_check (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_valid),
        .i_in_stall      (o_stall),
        .i_command       (i_command),
        .i_frame_kind    (i_frame_kind),
        .i_topic_len     (i_topic_len),
        .i_data_len      (i_data_len),
        .i_byte_in       (i_byte_in),
        .i_out_valid     (o_valid),
        .i_out_stall     (i_stall),
        .i_byte_out      (o_byte_out),
        .i_frame_end     (o_frame_end),
        .o_fail_count    (fail_count),
        .o_bytes_pending (bytes_pending)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        repeat (RUN_LIMIT) @(posedge i_clk);
        $display("*** FAILED ***");
        $finish;
    end

    // byte sink: after each taken byte, stall for a freshly drawn number of cycles if take_idle
    always @(posedge i_clk) begin
        if (o_valid && !i_stall) take_wait = take_idle ? $urandom_range(0, 15) : 0;
        else if (take_wait > 0) take_wait--;
        i_stall <= (take_wait != 0);
    end

    task automatic send_item(input logic cmd, input logic [1:0] kind,
                             input logic [15:0] tlen, input logic [23:0] dlen,
                             input logic [7:0] value);
        int gap;
        gap = send_idle ? $urandom_range(0, 15) : 0;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_command    <= cmd;
        i_frame_kind <= kind;
        i_topic_len  <= tlen;
        i_data_len   <= dlen;
        i_byte_in    <= value;
        i_valid      <= 1'b1;
        do @(posedge i_clk); while (o_stall);
        items_sent++;
    endtask

    // start item followed by body content items with random bytes and noise fields
    task automatic send_frame(input logic [1:0] kind, input logic [15:0] tlen,
                              input logic [23:0] dlen, input int body);
        send_item(CMD_START, kind, tlen, dlen, 8'($urandom));
        repeat (body) send_item(CMD_CONTENT, 2'($urandom), 16'($urandom), 24'($urandom),
                                8'($urandom));
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (bytes_pending != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    initial begin : stimulus
        int          stop_at;
        int          pick;
        int          full;
        bit          paused;
        logic [1:0]  kind;
        logic [15:0] tlen;
        logic [23:0] dlen;
        paused = 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed part
        send_item(CMD_CONTENT, KIND_QOS0, 16'h0000, 24'h000000, 8'hFF);
        send_item(CMD_START, KIND_QOS0, 16'h0000, 24'h000000, 8'h00);
        send_item(CMD_START, KIND_QOS1, 16'h0000, 24'h000000, 8'h00);
        send_item(CMD_START, KIND_SUB, 16'h0000, 24'hFFFFFF, 8'h00);
        // qos0 topic with no payload: last topic byte ends the frame
        send_item(CMD_START, KIND_QOS0, 16'h0002, 24'h000000, 8'h00);
        send_item(CMD_CONTENT, KIND_QOS0, 16'h0000, 24'h000000, 8'h00);
        send_item(CMD_CONTENT, KIND_QOS0, 16'h0000, 24'h000000, 8'hFF);
        send_item(CMD_START, KIND_QOS1, 16'h0001, 24'h000002, 8'h00);
        send_item(CMD_CONTENT, KIND_QOS0, 16'h0000, 24'h000000, 8'hAA);
        send_item(CMD_CONTENT, KIND_QOS0, 16'h0000, 24'h000000, 8'h55);
        send_item(CMD_CONTENT, KIND_QOS0, 16'h0000, 24'h000000, 8'hFF);
        send_item(CMD_START, KIND_SUB, 16'h0002, 24'h000000, 8'h00);
        send_item(CMD_CONTENT, KIND_QOS0, 16'h0000, 24'h000000, 8'h01);
        send_item(CMD_CONTENT, KIND_QOS0, 16'h0000, 24'h000000, 8'h80);
        send_item(CMD_CONTENT, KIND_QOS0, 16'h0000, 24'h000000, 8'h7F);
        send_item(CMD_START, KIND_NONE, 16'hFFFF, 24'hFFFFFF, 8'hFF);
        // largest lengths, four-byte varint, abandoned before the identifier
        send_item(CMD_START, KIND_QOS1, 16'hFFFF, 24'hFFFFFF, 8'h00);
        send_item(CMD_START, KIND_QOS0, 16'h0000, 24'h000001, 8'h00);
        send_item(CMD_CONTENT, KIND_QOS0, 16'h0000, 24'h000000, 8'h80);
        send_item(CMD_START, KIND_SUB, 16'hFFFF, 24'h000000, 8'h00);
        send_item(CMD_CONTENT, KIND_QOS0, 16'h0000, 24'h000000, 8'h5A);
        send_item(CMD_START, KIND_NONE, 16'h0000, 24'h000000, 8'h00);
        // remaining length 127 and 128, one and two varint bytes
        send_item(CMD_START, KIND_QOS0, 16'h0000, 24'd125, 8'h00);
        send_item(CMD_START, KIND_QOS0, 16'h0000, 24'd126, 8'h00);
        wait_drained();

        // random part
        stop_at = items_sent + RANDOM_ITEMS;
        while (items_sent < stop_at) begin
            if ($urandom_range(0, 39) == 0) begin
                send_idle <= ($urandom_range(0, 2) != 0);
                take_idle <= ($urandom_range(0, 2) != 0);
            end
            pick = int'($urandom_range(0, 99));
            kind = 2'($urandom_range(0, 2));
            tlen = 16'($urandom_range(0, 6));
            dlen = ($urandom_range(0, 9) == 0) ? 24'($urandom_range(0, 60))
                                               : 24'($urandom_range(0, 8));
            full = int'(tlen) + ((kind == KIND_SUB) ? 0 : int'(dlen));
            if (pick < 75) begin
                send_frame(kind, tlen, dlen, full);
            end else if (pick < 87) begin
                // cut short or run past the end
                send_frame(kind, tlen, dlen, int'($urandom_range(0, full + 2)));
            end else if (pick < 94) begin
                send_item(CMD_CONTENT, 2'($urandom), 16'($urandom), 24'($urandom),
                          8'($urandom));
            end else begin
                send_frame(2'($urandom_range(0, 3)), 16'($urandom), 24'($urandom),
                           int'($urandom_range(0, 3)));
            end
            if (!paused && items_sent >= stop_at - RANDOM_ITEMS / 2) begin
                paused = 1'b1;
                wait_drained();
            end
        end
        wait_drained();

        if (fail_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
